@@ src/assert_macros.svh @@
// Assertion macros shared by the placer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge, skipped while reset is high.
`define TASP_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define TASP_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

@@ src/tasp_pkg.sv @@
// Types, constants and helper functions of the texture atlas slot placer.
package tasp_pkg;

  // Largest texture and atlas side exponent handled.
  localparam int MAX_SIDE_LOG2 = 12;
  localparam int LOG2_W        = 4;
  localparam int SLOT_W        = 6;
  localparam int POS_W         = 13;
  localparam int BYTES_W       = 27;
  // Internal coordinate width: covers center plus gap plus stride rounding.
  localparam int COORD_W       = 16;
  localparam int APB_ADDR_W    = 3;
  localparam int APB_DATA_W    = 32;

  localparam logic [BYTES_W-1:0] BYTE_MAX = {BYTES_W{1'b1}};

  // Request kinds.
  localparam logic KIND_PLACE  = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic              kind;
    logic [LOG2_W-1:0] size_log2;
    logic [SLOT_W-1:0] slot;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [SLOT_W-1:0]  slot_used;
    logic [POS_W-1:0]   center_x;
    logic [POS_W-1:0]   center_y;
    logic [BYTES_W-1:0] used_bytes;
  } rsp_t;

  typedef struct packed {
    logic [LOG2_W-1:0] width_log2;
    logic [LOG2_W-1:0] height_log2;
  } cfg_t;

  // One table entry; a size-one texture is stored with exponent 0 and side 0.
  typedef struct packed {
    logic              valid;
    logic [LOG2_W-1:0] lg;
    logic [POS_W-1:0]  cx;
    logic [POS_W-1:0]  cy;
  } entry_t;

  // Result of the spacing check against one entry.
  typedef struct packed {
    logic               hit;
    logic [COORD_W-1:0] reach;
  } chk_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_RM_RD,
    ST_RM_CHK,
    ST_FREE_RD,
    ST_FREE_CHK,
    ST_CAND,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_SCAN_CMP,
    ST_SKIP,
    ST_PUT,
    ST_DONE
  } state_t;

  // Clamp an atlas exponent to the largest supported side.
  function automatic logic [LOG2_W-1:0] sat_log2(input logic [LOG2_W-1:0] l);
    return (l > LOG2_W'(MAX_SIDE_LOG2)) ? LOG2_W'(MAX_SIDE_LOG2) : l;
  endfunction

  // First candidate center on one axis.
  function automatic logic [COORD_W-1:0] axis_beg(input logic [LOG2_W-1:0] lg,
                                                  input logic [LOG2_W-1:0] alog);
    logic [COORD_W-1:0] s;
    s = COORD_W'(1) << lg;
    if (lg == '0) begin
      return '0;
    end else if (lg == alog) begin
      return s >> 1;
    end else begin
      return s;
    end
  endfunction

  // Last candidate center on one axis (inclusive).
  function automatic logic [COORD_W-1:0] axis_end(input logic [LOG2_W-1:0] lg,
                                                  input logic [LOG2_W-1:0] alog);
    logic [COORD_W-1:0] s;
    logic [COORD_W-1:0] a;
    s = COORD_W'(1) << lg;
    a = COORD_W'(1) << alog;
    if (lg == '0) begin
      return a;
    end else if (lg == alog) begin
      return s >> 1;
    end else begin
      return a - s;
    end
  endfunction

  // Bytes of a full mip chain of side 2^lg at four bytes a texel.
  function automatic logic [BYTES_W-1:0] chain_bytes(input logic [LOG2_W-1:0] lg);
    logic [BYTES_W-1:0] b;
    case (lg)
      4'd0:    b = 27'd4;
      4'd1:    b = 27'd20;
      4'd2:    b = 27'd84;
      4'd3:    b = 27'd340;
      4'd4:    b = 27'd1364;
      4'd5:    b = 27'd5460;
      4'd6:    b = 27'd21844;
      4'd7:    b = 27'd87380;
      4'd8:    b = 27'd349524;
      4'd9:    b = 27'd1398100;
      4'd10:   b = 27'd5592404;
      4'd11:   b = 27'd22369620;
      4'd12:   b = 27'd89478484;
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

@@ src/tasp_ram.sv @@
// Generic single-port RAM with registered read data.
module tasp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ src/tasp_cfg.sv @@
// APB configuration registers holding the atlas side exponents.
module tasp_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tasp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tasp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tasp_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready,
  output tasp_pkg::cfg_t                   cfg
);

  tasp_pkg::reg_idx_t reg_idx;
  logic               wr_en;

  assign reg_idx = tasp_pkg::reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Write the addressed register in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width_log2  <= tasp_pkg::LOG2_W'(tasp_pkg::MAX_SIDE_LOG2);
      cfg.height_log2 <= tasp_pkg::LOG2_W'(tasp_pkg::MAX_SIDE_LOG2);
    end else if (wr_en) begin
      case (reg_idx)
        tasp_pkg::REG_WIDTH:  cfg.width_log2  <= pwdata[tasp_pkg::LOG2_W-1:0];
        tasp_pkg::REG_HEIGHT: cfg.height_log2 <= pwdata[tasp_pkg::LOG2_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register.
  always_comb begin
    case (reg_idx)
      tasp_pkg::REG_WIDTH:  prdata = tasp_pkg::APB_DATA_W'(cfg.width_log2);
      tasp_pkg::REG_HEIGHT: prdata = tasp_pkg::APB_DATA_W'(cfg.height_log2);
      default:              prdata = '0;
    endcase
  end

endmodule

@@ src/tasp_gap_unit.sv @@
// Shared spacing check of one candidate center against one table entry.
module tasp_gap_unit (
  input  logic                              clk,
  input  logic                              load,
  input  tasp_pkg::entry_t                  entry,
  input  logic [tasp_pkg::LOG2_W-1:0]       new_lg,
  input  logic [tasp_pkg::COORD_W-1:0]      cand_x,
  input  logic [tasp_pkg::COORD_W-1:0]      cand_y,
  input  logic [tasp_pkg::COORD_W-1:0]      bx,
  output tasp_pkg::chk_t                    chk
);

  localparam int CW = tasp_pkg::COORD_W;

  logic [CW-1:0] e_side;
  logic [CW-1:0] s_side;
  logic [CW-1:0] big;
  logic [CW-1:0] sml;
  logic [CW-1:0] ecx;
  logic [CW-1:0] ecy;
  logic [CW-1:0] gap_c;
  logic [CW-1:0] dx_c;
  logic [CW-1:0] dy_c;

  logic          e_valid;
  logic [CW-1:0] gap;
  logic [CW-1:0] dx;
  logic [CW-1:0] dy;
  logic [CW-1:0] ent_cx;

  // Minimum distance and axis distances from the entry just read.
  always_comb begin
    e_side = (entry.lg == '0) ? '0 : (CW'(1) << entry.lg);
    s_side = CW'(1) << new_lg;
    big    = (e_side > s_side) ? e_side : s_side;
    sml    = (e_side > s_side) ? s_side : e_side;
    gap_c  = (big == sml) ? (big << 1) : ((big >> 1) + (sml << 1));
    ecx    = CW'(entry.cx);
    ecy    = CW'(entry.cy);
    dx_c   = (ecx > cand_x) ? (ecx - cand_x) : (cand_x - ecx);
    dy_c   = (ecy > cand_y) ? (ecy - cand_y) : (cand_y - ecy);
  end

  // Hold the evaluated terms for the compare step.
  always_ff @(posedge clk) begin
    if (load) begin
      e_valid <= entry.valid;
      gap     <= gap_c;
      dx      <= dx_c;
      dy      <= dy_c;
      ent_cx  <= ecx;
    end
  end

  // Reject when both axes are too close; distance past the first column is the skip.
  assign chk.hit   = e_valid && (dx < gap) && (dy < gap);
  assign chk.reach = ent_cx + gap - bx;

endmodule

@@ src/texture_atlas_slot_placer_top.sv @@
// Top level of the texture atlas slot placer: sequencer, table and result register.
//
// Places square power-of-two textures into a power-of-two atlas and frees them again,
// one request at a time, one result per request. After reset the table is cleared entry by
// entry before the first request is taken. A remove reads the addressed entry and clears it
// if valid; a slot beyond the table is answered without a table access. A place first reads
// the table entry by entry up to the lowest free slot, then tests candidate centers row by
// row: each test reads the table entries in order through one shared spacing check unit
// (read, evaluate, compare per entry), stopping at the first entry that blocks it, and a
// rejected candidate then jumps past the blocking entry. The result sits in an output
// register, so a new request is taken while it waits to be read.
module texture_atlas_slot_placer_top #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  tasp_pkg::req_t                   req,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output tasp_pkg::rsp_t                   rsp,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tasp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tasp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tasp_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready
);

  `include "assert_macros.svh"

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_ENTRIES - 1);
  localparam int CW  = tasp_pkg::COORD_W;
  localparam int BW  = tasp_pkg::BYTES_W;

  tasp_pkg::state_t state;
  tasp_pkg::state_t state_next;

  tasp_pkg::cfg_t   cfg;
  tasp_pkg::entry_t ram_rdata;
  tasp_pkg::entry_t ram_wdata;
  tasp_pkg::chk_t   chk;
  logic [IDX_W-1:0] ram_addr;
  logic             ram_we;
  logic             unit_load;
  logic             rsp_load;

  logic [IDX_W-1:0]            idx;
  logic [IDX_W-1:0]            free_slot;
  logic [tasp_pkg::LOG2_W-1:0] op_lg;
  logic [tasp_pkg::SLOT_W-1:0] op_slot;
  logic [CW-1:0]               bx;
  logic [CW-1:0]               ex;
  logic [CW-1:0]               ey;
  logic [CW-1:0]               stride;
  logic [CW-1:0]               cand_x;
  logic [CW-1:0]               cand_y;
  logic [CW-1:0]               reach;
  logic [BW-1:0]               byte_total;
  logic                        r_ok;
  logic [tasp_pkg::SLOT_W-1:0] r_slot;
  logic [tasp_pkg::POS_W-1:0]  r_cx;
  logic [tasp_pkg::POS_W-1:0]  r_cy;

  logic [tasp_pkg::LOG2_W-1:0] wl_s;
  logic [tasp_pkg::LOG2_W-1:0] hl_s;
  logic                        req_fire;
  logic                        fits;
  logic                        slot_ok;
  logic [IDX_W-1:0]            slot_idx;
  logic [BW-1:0]               rm_bytes;
  logic [BW:0]                 add_sum;
  logic [CW-1:0]               stride_mask;

  tasp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tasp_ram #(
    .WIDTH ($bits(tasp_pkg::entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  tasp_gap_unit u_gap (
    .clk    (clk),
    .load   (unit_load),
    .entry  (ram_rdata),
    .new_lg (op_lg),
    .cand_x (cand_x),
    .cand_y (cand_y),
    .bx     (bx),
    .chk    (chk)
  );

  // Request decode.
  assign req_ready   = (state == tasp_pkg::ST_IDLE);
  assign req_fire    = req_valid && req_ready;
  assign wl_s        = tasp_pkg::sat_log2(cfg.width_log2);
  assign hl_s        = tasp_pkg::sat_log2(cfg.height_log2);
  assign fits        = (req.size_log2 <= wl_s) && (req.size_log2 <= hl_s);
  assign slot_ok     = (32'(req.slot) < 32'(MAX_ENTRIES));
  assign slot_idx    = IDX_W'(op_slot);
  assign rm_bytes    = (ram_rdata.lg == '0) ? '0 : tasp_pkg::chain_bytes(ram_rdata.lg);
  assign add_sum     = {1'b0, byte_total} + {1'b0, tasp_pkg::chain_bytes(op_lg)};
  assign stride_mask = stride - CW'(1);
  assign rsp_load    = (state == tasp_pkg::ST_DONE) && (!rsp_valid || rsp_ready);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      tasp_pkg::ST_CLR: begin
        if (idx == IDX_LAST) state_next = tasp_pkg::ST_IDLE;
      end
      tasp_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (req.kind == tasp_pkg::KIND_REMOVE) begin
            state_next = slot_ok ? tasp_pkg::ST_RM_RD : tasp_pkg::ST_DONE;
          end else begin
            state_next = fits ? tasp_pkg::ST_FREE_RD : tasp_pkg::ST_DONE;
          end
        end
      end
      tasp_pkg::ST_RM_RD:   state_next = tasp_pkg::ST_RM_CHK;
      tasp_pkg::ST_RM_CHK:  state_next = tasp_pkg::ST_DONE;
      tasp_pkg::ST_FREE_RD: state_next = tasp_pkg::ST_FREE_CHK;
      tasp_pkg::ST_FREE_CHK: begin
        if (!ram_rdata.valid) begin
          state_next = tasp_pkg::ST_CAND;
        end else if (idx == IDX_LAST) begin
          state_next = tasp_pkg::ST_DONE;
        end else begin
          state_next = tasp_pkg::ST_FREE_RD;
        end
      end
      tasp_pkg::ST_CAND: begin
        if (cand_y > ey) begin
          state_next = tasp_pkg::ST_DONE;
        end else if (cand_x <= ex) begin
          state_next = tasp_pkg::ST_SCAN_RD;
        end
      end
      tasp_pkg::ST_SCAN_RD: state_next = tasp_pkg::ST_SCAN_EV;
      tasp_pkg::ST_SCAN_EV: state_next = tasp_pkg::ST_SCAN_CMP;
      tasp_pkg::ST_SCAN_CMP: begin
        if (chk.hit) begin
          state_next = tasp_pkg::ST_SKIP;
        end else if (idx == IDX_LAST) begin
          state_next = tasp_pkg::ST_PUT;
        end else begin
          state_next = tasp_pkg::ST_SCAN_RD;
        end
      end
      tasp_pkg::ST_SKIP: state_next = tasp_pkg::ST_CAND;
      tasp_pkg::ST_PUT:  state_next = tasp_pkg::ST_DONE;
      tasp_pkg::ST_DONE: begin
        if (!rsp_valid || rsp_ready) state_next = tasp_pkg::ST_IDLE;
      end
      default: state_next = tasp_pkg::ST_IDLE;
    endcase
  end

  // Table access and check unit control.
  always_comb begin
    ram_addr  = idx;
    ram_we    = 1'b0;
    ram_wdata = '0;
    unit_load = 1'b0;
    case (state)
      tasp_pkg::ST_CLR: begin
        ram_we = 1'b1;
      end
      tasp_pkg::ST_RM_RD: begin
        ram_addr = slot_idx;
      end
      tasp_pkg::ST_RM_CHK: begin
        ram_addr = slot_idx;
        ram_we   = ram_rdata.valid;
      end
      tasp_pkg::ST_SCAN_EV: begin
        unit_load = 1'b1;
      end
      tasp_pkg::ST_PUT: begin
        ram_addr        = free_slot;
        ram_we          = 1'b1;
        ram_wdata.valid = 1'b1;
        ram_wdata.lg    = op_lg;
        ram_wdata.cx    = tasp_pkg::POS_W'(cand_x);
        ram_wdata.cy    = tasp_pkg::POS_W'(cand_y);
      end
      default: ;
    endcase
  end

  // Control registers: state, entry counter, byte total, result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tasp_pkg::ST_CLR;
      idx        <= '0;
      byte_total <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        tasp_pkg::ST_CLR: begin
          if (idx != IDX_LAST) idx <= idx + IDX_W'(1);
        end
        tasp_pkg::ST_IDLE: idx <= '0;
        tasp_pkg::ST_RM_CHK: begin
          if (ram_rdata.valid) begin
            byte_total <= (byte_total > rm_bytes) ? (byte_total - rm_bytes) : '0;
          end
        end
        tasp_pkg::ST_FREE_CHK: begin
          if (ram_rdata.valid && idx != IDX_LAST) idx <= idx + IDX_W'(1);
        end
        tasp_pkg::ST_CAND: idx <= '0;
        tasp_pkg::ST_SCAN_CMP: begin
          if (!chk.hit && idx != IDX_LAST) idx <= idx + IDX_W'(1);
        end
        tasp_pkg::ST_PUT: begin
          byte_total <= (add_sum > {1'b0, tasp_pkg::BYTE_MAX}) ? tasp_pkg::BYTE_MAX
                                                              : add_sum[BW-1:0];
        end
        default: ;
      endcase
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers: request, scan window, candidate and pending result.
  always_ff @(posedge clk) begin
    case (state)
      tasp_pkg::ST_IDLE: begin
        if (req_fire) begin
          op_lg   <= req.size_log2;
          op_slot <= req.slot;
          r_ok    <= 1'b0;
          r_slot  <= '0;
          r_cx    <= '0;
          r_cy    <= '0;
          bx      <= tasp_pkg::axis_beg(req.size_log2, wl_s);
          ex      <= tasp_pkg::axis_end(req.size_log2, wl_s);
          ey      <= tasp_pkg::axis_end(req.size_log2, hl_s);
          stride  <= CW'(2) << req.size_log2;
          cand_x  <= tasp_pkg::axis_beg(req.size_log2, wl_s);
          cand_y  <= tasp_pkg::axis_beg(req.size_log2, hl_s);
        end
      end
      tasp_pkg::ST_RM_CHK: begin
        if (ram_rdata.valid) begin
          r_ok   <= 1'b1;
          r_slot <= op_slot;
        end
      end
      tasp_pkg::ST_FREE_CHK: begin
        if (!ram_rdata.valid) free_slot <= idx;
      end
      tasp_pkg::ST_CAND: begin
        // Past the row end: step to the next row.
        if (cand_y <= ey && cand_x > ex) begin
          cand_y <= cand_y + stride;
          cand_x <= bx;
        end
      end
      tasp_pkg::ST_SCAN_CMP: reach <= chk.reach;
      tasp_pkg::ST_SKIP: begin
        // Jump to the first column at or beyond the blocking entry's reach.
        cand_x <= bx + ((reach + stride_mask) & ~stride_mask);
      end
      tasp_pkg::ST_PUT: begin
        r_ok   <= 1'b1;
        r_slot <= tasp_pkg::SLOT_W'(free_slot);
        r_cx   <= tasp_pkg::POS_W'(cand_x);
        r_cy   <= tasp_pkg::POS_W'(cand_y);
      end
      default: ;
    endcase
    if (rsp_load) begin
      rsp.ok         <= r_ok;
      rsp.slot_used  <= r_slot;
      rsp.center_x   <= r_cx;
      rsp.center_y   <= r_cy;
      rsp.used_bytes <= byte_total;
    end
  end

  `TASP_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (state == tasp_pkg::ST_CLR && idx == '0), "reset must start the clearing pass")
  `TASP_ASSERT(a_idx_range, clk, rst, idx <= IDX_LAST, "entry counter beyond the table")
  `TASP_ASSERT(a_cand_window, clk, rst, (state == tasp_pkg::ST_SCAN_RD) |-> (cand_x <= ex && cand_y <= ey), "candidate outside the scan window")
  `TASP_ASSERT(a_skip_advance, clk, rst, (state == tasp_pkg::ST_SKIP) |=> (cand_x > $past(cand_x)), "skip did not advance the candidate")
  `TASP_ASSERT(a_rsp_from_done, clk, rst, $rose(rsp_valid) |-> $past(state == tasp_pkg::ST_DONE), "result raised outside the done step")

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the texture atlas slot placer.
`timescale 1ns / 1ps

module testbench;

  localparam int TABLE_DEPTH = 64;
  localparam int unsigned BYTE_CAP = (1 << tasp_pkg::BYTES_W) - 1;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  tasp_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  tasp_pkg::rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [tasp_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [tasp_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [tasp_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  texture_atlas_slot_placer_top DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Mirror of the placer: atlas setting, slot table and byte total
  logic [tasp_pkg::LOG2_W-1:0] width_lg = tasp_pkg::LOG2_W'(12);
  logic [tasp_pkg::LOG2_W-1:0] height_lg = tasp_pkg::LOG2_W'(12);
  bit slot_valid [TABLE_DEPTH];
  int unsigned slot_side [TABLE_DEPTH];
  int unsigned slot_cx [TABLE_DEPTH];
  int unsigned slot_cy [TABLE_DEPTH];
  int unsigned bytes_held = 0;

  tasp_pkg::req_t queued_reqs [$];
  tasp_pkg::rsp_t due_rsps [$];

  bit req_taken = 1'b0;
  bit calm = 1'b0;
  int send_gap = 0;
  int hold_left = 0;
  int mismatches = 0;
  int results_seen = 0;
  int placed = 0;
  int refused = 0;
  int removed = 0;
  int bad_removes = 0;
  int settings = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(64'd300_000_000);
    $display("testbench NOT OK");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // Bytes of a full mip chain down to one texel
  function automatic int unsigned mip_bytes(input int unsigned s);
    int unsigned sum;
    sum = 0;
    while (s > 0) begin
      sum += s * s * 4;
      s = s >> 1;
    end
    return sum;
  endfunction

  function automatic int unsigned spacing(input int unsigned e, input int unsigned s);
    int unsigned big;
    int unsigned lesser;
    big = (e > s) ? e : s;
    lesser = (e > s) ? s : e;
    if (big == lesser) return 2 * big;
    return big / 2 + 2 * lesser;
  endfunction

  function automatic int unsigned gap_of(input int unsigned a, input int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Candidate center span on one axis of side a
  function automatic void axis_span(input int unsigned s, input int unsigned a,
                                    output int unsigned b, output int unsigned e);
    if (s == 1) begin
      b = 0;
      e = a;
    end else if (s == a) begin
      b = s / 2;
      e = s / 2;
    end else begin
      b = s;
      e = a - s;
    end
  endfunction

  // Scan rows then columns; jump past the first entry that blocks a candidate
  function automatic bit find_center(input int unsigned s, input int unsigned aw,
                                     input int unsigned ah, output int unsigned ox,
                                     output int unsigned oy);
    int unsigned bx, ex, by, ey, stride, x, y, g, lim, k;
    bit hit;
    ox = 0;
    oy = 0;
    stride = 2 * s;
    axis_span(s, aw, bx, ex);
    axis_span(s, ah, by, ey);
    for (y = by; y <= ey; y += stride) begin
      x = bx;
      while (x <= ex) begin
        hit = 1'b0;
        for (int i = 0; i < TABLE_DEPTH && !hit; i++) begin
          if (slot_valid[i]) begin
            g = spacing(slot_side[i], s);
            if (gap_of(slot_cx[i], x) < g && gap_of(slot_cy[i], y) < g) begin
              lim = slot_cx[i] + g;
              k = (lim - bx + stride - 1) / stride;
              x = bx + k * stride;
              hit = 1'b1;
            end
          end
        end
        if (!hit) begin
          ox = x;
          oy = y;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // Apply one request to the mirror and return the result it must produce
  function automatic tasp_pkg::rsp_t atlas_request(input tasp_pkg::req_t r);
    tasp_pkg::rsp_t o;
    int unsigned wl, hl, s, b, cx, cy, free_slot;
    bit have;
    o = '0;
    if (r.kind == tasp_pkg::KIND_REMOVE) begin
      if (slot_valid[r.slot]) begin
        b = mip_bytes(slot_side[r.slot]);
        slot_valid[r.slot] = 1'b0;
        bytes_held = (bytes_held > b) ? bytes_held - b : 0;
        o.ok = 1'b1;
        o.slot_used = r.slot;
      end
    end else begin
      wl = (width_lg > tasp_pkg::MAX_SIDE_LOG2) ? tasp_pkg::MAX_SIDE_LOG2 : width_lg;
      hl = (height_lg > tasp_pkg::MAX_SIDE_LOG2) ? tasp_pkg::MAX_SIDE_LOG2 : height_lg;
      if (r.size_log2 <= tasp_pkg::MAX_SIDE_LOG2 && r.size_log2 <= wl &&
          r.size_log2 <= hl) begin
        s = 1 << r.size_log2;
        have = 1'b0;
        free_slot = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (!have && !slot_valid[i]) begin
            free_slot = i;
            have = 1'b1;
          end
        end
        if (have) begin
          if (find_center(s, 1 << wl, 1 << hl, cx, cy)) begin
            b = mip_bytes(s);
            slot_valid[free_slot] = 1'b1;
            slot_side[free_slot] = (s > 1) ? s : 0;
            slot_cx[free_slot] = cx;
            slot_cy[free_slot] = cy;
            bytes_held = (BYTE_CAP - bytes_held < b) ? BYTE_CAP : bytes_held + b;
            o.ok = 1'b1;
            o.slot_used = tasp_pkg::SLOT_W'(free_slot);
            o.center_x = tasp_pkg::POS_W'(cx);
            o.center_y = tasp_pkg::POS_W'(cy);
          end
        end
      end
    end
    o.used_bytes = tasp_pkg::BYTES_W'(bytes_held);
    return o;
  endfunction

  // Mostly short gaps, a few long ones, none in calm stretches
  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive the next request at the falling edge; hold it until taken
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        req_valid <= 1'b0;
      end else if (queued_reqs.size() != 0) begin
        req <= queued_reqs[0];
        req_valid <= 1'b1;
        send_gap = pick_gap(calm);
      end else begin
        req_valid <= 1'b0;
      end
    end
    req_taken = 1'b0;
  end

  // Stall the result side at random
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
      hold_left = pick_gap(calm);
    end
  end

  // Predict each accepted transaction
  always @(posedge clk) begin : take_req
    tasp_pkg::rsp_t want;
    if (!rst && req_valid && req_ready) begin
      want = atlas_request(req);
      due_rsps.push_back(want);
      void'(queued_reqs.pop_front());
      req_taken = 1'b1;
      if (req.kind == tasp_pkg::KIND_REMOVE) begin
        if (want.ok) removed++;
        else bad_removes++;
      end else begin
        if (want.ok) placed++;
        else refused++;
      end
    end
  end

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin : check_rsp
    tasp_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      results_seen++;
      if (due_rsps.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with nothing outstanding", results_seen));
      end else begin
        want = due_rsps.pop_front();
        if (rsp.ok !== want.ok)
          flag_mismatch($sformatf("result %0d ok %0d, want %0d",
                                  results_seen, rsp.ok, want.ok));
        if (rsp.slot_used !== want.slot_used)
          flag_mismatch($sformatf("result %0d slot_used %0d, want %0d",
                                  results_seen, rsp.slot_used, want.slot_used));
        if (rsp.center_x !== want.center_x)
          flag_mismatch($sformatf("result %0d center_x %0d, want %0d",
                                  results_seen, rsp.center_x, want.center_x));
        if (rsp.center_y !== want.center_y)
          flag_mismatch($sformatf("result %0d center_y %0d, want %0d",
                                  results_seen, rsp.center_y, want.center_y));
        if (rsp.used_bytes !== want.used_bytes)
          flag_mismatch($sformatf("result %0d used_bytes %0d, want %0d",
                                  results_seen, rsp.used_bytes, want.used_bytes));
      end
    end
  end

  // Write one register, then read it back
  task automatic write_reg(input tasp_pkg::reg_idx_t idx,
                           input logic [tasp_pkg::LOG2_W-1:0] value);
    logic [tasp_pkg::APB_DATA_W-1:0] got;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= tasp_pkg::APB_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == tasp_pkg::REG_WIDTH) width_lg = value;
    else height_lg = value;
    @(negedge clk);
    psel <= 1'b1;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got[tasp_pkg::LOG2_W-1:0] !== value)
      flag_mismatch($sformatf("register %s reads %0d, want %0d", idx.name(),
                              got[tasp_pkg::LOG2_W-1:0], value));
  endtask

  task automatic push_place(input int lg);
    tasp_pkg::req_t r;
    r.kind = tasp_pkg::KIND_PLACE;
    r.size_log2 = tasp_pkg::LOG2_W'(lg);
    r.slot = tasp_pkg::SLOT_W'($urandom_range(0, 63));
    queued_reqs.push_back(r);
  endtask

  task automatic push_remove(input int slot);
    tasp_pkg::req_t r;
    r.kind = tasp_pkg::KIND_REMOVE;
    r.size_log2 = tasp_pkg::LOG2_W'($urandom_range(0, 15));
    r.slot = tasp_pkg::SLOT_W'(slot);
    queued_reqs.push_back(r);
  endtask

  // Wait until every request is taken and every result is back
  task automatic drain();
    while (queued_reqs.size() != 0 || due_rsps.size() != 0) @(posedge clk);
  endtask

  task automatic clear_table();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (slot_valid[i]) push_remove(i);
    end
    drain();
  endtask

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) n += slot_valid[i];
    return n;
  endfunction

  initial begin : stimulus
    int ph, n, j, pick, idx, lo, minl, maxl, wl, hl;
    logic [tasp_pkg::LOG2_W-1:0] w, h;
    int live [$];

    for (int i = 0; i < TABLE_DEPTH; i++) begin
      slot_valid[i] = 1'b0;
      slot_side[i] = 0;
      slot_cx[i] = 0;
      slot_cy[i] = 0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    settings = 1;

    // Too large, bad removes, whole-atlas texture and no room around it
    push_place(15);
    push_remove(0);
    push_remove(63);
    push_place(12);
    push_place(8);
    drain();
    // Size-one place and removal, then a half-size texture blocking its neighbors
    push_remove(0);
    push_place(0);
    push_remove(0);
    push_place(11);
    push_place(10);
    drain();
    push_remove(0);
    repeat (4) push_place(10);
    push_place(9);
    drain();
    clear_table();

    // Extreme atlas shapes: one texel wide, then one texel tall
    write_reg(tasp_pkg::REG_WIDTH, tasp_pkg::LOG2_W'(0));
    write_reg(tasp_pkg::REG_HEIGHT, tasp_pkg::LOG2_W'(15));
    settings++;
    push_place(0);
    push_place(1);
    push_place(0);
    drain();
    clear_table();
    write_reg(tasp_pkg::REG_WIDTH, tasp_pkg::LOG2_W'(15));
    write_reg(tasp_pkg::REG_HEIGHT, tasp_pkg::LOG2_W'(0));
    settings++;
    push_place(0);
    push_place(3);
    drain();
    clear_table();

    // Fill the table with size-one textures, then overflow it
    write_reg(tasp_pkg::REG_WIDTH, tasp_pkg::LOG2_W'(2));
    write_reg(tasp_pkg::REG_HEIGHT, tasp_pkg::LOG2_W'(2));
    settings++;
    repeat (TABLE_DEPTH - live_count()) push_place(0);
    push_place(0);
    push_place(1);
    drain();
    clear_table();

    // Random phases, each under its own atlas setting
    for (ph = 0; ph < 13; ph++) begin
      if ($urandom_range(0, 9) < 7) clear_table();
      case ($urandom_range(0, 9))
        0: begin
          w = '0;
          h = '0;
        end
        1: begin
          w = tasp_pkg::LOG2_W'($urandom_range(12, 15));
          h = tasp_pkg::LOG2_W'($urandom_range(12, 15));
        end
        2: begin
          w = tasp_pkg::LOG2_W'($urandom_range(0, 5));
          h = tasp_pkg::LOG2_W'($urandom_range(0, 5));
        end
        default: begin
          w = tasp_pkg::LOG2_W'($urandom_range(1, 5));
          h = tasp_pkg::LOG2_W'($urandom_range(1, 5));
        end
      endcase
      write_reg(tasp_pkg::REG_WIDTH, w);
      write_reg(tasp_pkg::REG_HEIGHT, h);
      settings++;
      calm = ($urandom_range(0, 3) == 0);
      wl = (w > tasp_pkg::MAX_SIDE_LOG2) ? tasp_pkg::MAX_SIDE_LOG2 : w;
      hl = (h > tasp_pkg::MAX_SIDE_LOG2) ? tasp_pkg::MAX_SIDE_LOG2 : h;
      minl = (wl < hl) ? wl : hl;
      maxl = (wl > hl) ? wl : hl;
      // Keep textures within a few halvings of the atlas so scans stay short
      lo = (maxl > 3) ? maxl - 3 : 0;
      for (n = 0; n < 6; n++) begin
        live.delete();
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (slot_valid[i]) live.push_back(i);
        end
        for (j = 0; j < 6; j++) begin
          pick = $urandom_range(0, 99);
          if (pick < 40 && live.size() != 0) begin
            idx = $urandom_range(0, live.size() - 1);
            push_remove(live[idx]);
            live.delete(idx);
          end else if (pick < 46) begin
            push_remove($urandom_range(0, 63));
          end else if (pick < 53 || lo > minl) begin
            push_place($urandom_range((minl < 15) ? minl + 1 : 15, 15));
          end else begin
            push_place($urandom_range(lo, minl));
          end
        end
        drain();
      end
    end

    drain();
    repeat (300) @(negedge clk);
    $display("Covered %0d requests over %0d atlas settings, %0d results checked.",
             placed + refused + removed + bad_removes, settings, results_seen);
    $display("Placed %0d, refused %0d places, removed %0d, rejected %0d removes.",
             placed, refused, removed, bad_removes);
    if (mismatches == 0 && due_rsps.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
